// ===== sv/ppu_pkg.sv =====
`default_nettype none
package ppu_pkg;

  // operation codes of an input item
  localparam logic OP_SPAWN = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // configuration register indexes
  localparam logic CFG_LIFETIME   = 1'b0;
  localparam logic CFG_START_TIME = 1'b1;

  localparam logic [15:0] LIFE_RESET = 16'd4000;

  // byte steps of the divide by 125, and total update latency
  localparam int DIV_STEPS = 8;
  localparam int UPD_LAT   = DIV_STEPS + 2;

  typedef struct packed {
    logic               alive;
    logic [31:0]        age;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic [31:0]        color;
    logic [7:0]         size;
  } particle_t;

  typedef struct packed {
    logic               accepted;
    logic               has_particle;
    logic [5:0]         slot;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [31:0]        color;
    logic [7:0]         size;
    logic               last;
  } result_t;

  // slot freed by the update pipeline
  typedef struct packed {
    logic       valid;
    logic [5:0] slot;
  } push_t;

endpackage
`default_nettype wire

// ===== sv/ppu_ram.sv =====
`default_nettype none
module ppu_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/ppu_cell.sv =====
`default_nettype none
module ppu_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               shift_en,
  input  wire ppu_pkg::particle_t d_in,
  input  wire logic               load_en,
  input  wire ppu_pkg::particle_t load_d,
  output ppu_pkg::particle_t      q
);
  import ppu_pkg::*;

  // one slot of the ring: loaded by a spawn, passed on during a tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q.alive <= 1'b0;
    end else if (load_en) begin
      q <= load_d;
    end else if (shift_en) begin
      q <= d_in;
    end
  end

endmodule
`default_nettype wire

// ===== sv/ppu_update.sv =====
`default_nettype none
module ppu_update (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic [31:0]        dt,
  input  wire logic [15:0]        life_lim,
  input  wire ppu_pkg::particle_t d_in,
  input  wire logic [5:0]         slot_in,
  output ppu_pkg::particle_t      d_out,
  output logic [5:0]              slot_out,
  output ppu_pkg::push_t          push
);
  import ppu_pkg::*;

  typedef struct packed {
    particle_t        p;
    logic [5:0]       slot;
    logic [2:0]       neg;
    logic [2:0][63:0] dvd;
    logic [2:0][63:0] quo;
    logic [2:0][6:0]  rem;
  } stage_t;

  stage_t    st_r   [DIV_STEPS+1];
  stage_t    st_nxt [DIV_STEPS+1];
  particle_t fin_r;
  particle_t fin_nxt;
  logic [5:0] fin_slot_r;

  // one quotient byte of (rem:byte) / 125, rem < 125 keeps the value below 32000
  function automatic logic [14:0] div125(input logic [14:0] v);
    logic [32:0] m;
    logic [7:0]  q;
    logic [14:0] qm;
    m  = 33'(v) * 33'd134218;
    q  = m[31:24];
    qm = 15'(q) * 15'd125;
    return {q, 7'(v - qm)};
  endfunction

  // entry stage: death test, age, |vel| * dt
  logic              dies;
  logic [32:0]       age_sum;
  logic [2:0][31:0]  vel;
  logic [2:0][31:0]  vmag;
  logic [2:0][63:0]  prod;

  always_comb begin
    vel[0]  = d_in.vx;
    vel[1]  = d_in.vy;
    vel[2]  = d_in.vz;
    dies    = d_in.alive && (d_in.age > {16'd0, life_lim});
    age_sum = {1'b0, d_in.age} + {1'b0, dt};
    st_nxt[0]         = '0;
    st_nxt[0].p       = d_in;
    st_nxt[0].p.alive = d_in.alive && !dies;
    st_nxt[0].p.age   = age_sum[32] ? 32'hFFFF_FFFF : age_sum[31:0];
    st_nxt[0].slot    = slot_in;
    for (int a = 0; a < 3; a++) begin
      vmag[a] = vel[a][31] ? (32'd0 - vel[a]) : vel[a];
      prod[a] = 64'(vmag[a]) * 64'(dt);
      st_nxt[0].neg[a] = vel[a][31];
      st_nxt[0].dvd[a] = {3'd0, prod[a][63:3]};
    end
  end

  assign push.valid = en && dies;
  assign push.slot  = slot_in;

  // long division of |vel*dt|/8 by 125, one byte per stage
  always_comb begin
    logic [14:0] dr;
    dr = '0;
    for (int k = 1; k <= DIV_STEPS; k++) begin
      st_nxt[k] = st_r[k-1];
      for (int a = 0; a < 3; a++) begin
        dr = div125({st_r[k-1].rem[a], st_r[k-1].dvd[a][63:56]});
        st_nxt[k].quo[a] = {st_r[k-1].quo[a][55:0], dr[14:7]};
        st_nxt[k].rem[a] = dr[6:0];
        st_nxt[k].dvd[a] = {st_r[k-1].dvd[a][55:0], 8'd0};
      end
    end
  end

  // last stage: signed step added to position, saturated to 32 bits
  logic [2:0][31:0] pos;
  logic [2:0][31:0] npos;
  logic [2:0][63:0] step;
  logic [2:0][63:0] sum;
  logic [2:0]       ovf;

  always_comb begin
    pos[0] = st_r[DIV_STEPS].p.x;
    pos[1] = st_r[DIV_STEPS].p.y;
    pos[2] = st_r[DIV_STEPS].p.z;
    for (int a = 0; a < 3; a++) begin
      step[a] = st_r[DIV_STEPS].neg[a] ? (64'd0 - st_r[DIV_STEPS].quo[a])
                                       : st_r[DIV_STEPS].quo[a];
      sum[a]  = {{32{pos[a][31]}}, pos[a]} + step[a];
      ovf[a]  = !(&sum[a][63:31]) && (|sum[a][63:31]);
      npos[a] = ovf[a] ? (sum[a][63] ? 32'h8000_0000 : 32'h7FFF_FFFF) : sum[a][31:0];
    end
    fin_nxt   = st_r[DIV_STEPS].p;
    fin_nxt.x = npos[0];
    fin_nxt.y = npos[1];
    fin_nxt.z = npos[2];
  end

  // stage registers, only the alive marks are cleared
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= DIV_STEPS; i++) begin
        st_r[i].p.alive <= 1'b0;
      end
      fin_r.alive <= 1'b0;
    end else if (en) begin
      for (int i = 0; i <= DIV_STEPS; i++) begin
        st_r[i] <= st_nxt[i];
      end
      fin_r      <= fin_nxt;
      fin_slot_r <= st_r[DIV_STEPS].slot;
    end
  end

  assign d_out    = fin_r;
  assign slot_out = fin_slot_r;

endmodule
`default_nettype wire

// ===== sv/particle_pool_update_core.sv =====
// channel | direction | handshake           | payload
// in_     | input     | in_valid / in_stall   | operation, time, colour, position, velocity, size
// out_    | output    | out_valid / out_stall | accepted, has_particle, slot, x/y/z, colour, size, last
// cfg_    | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// a spawn reads the free stack top, then loads the slot once the result can advance.
// a tick rotates the ring of POOL_SIZE slots through a 10 stage update pipeline,
// one slot a cycle unless the result stalls, then a flush state closes the item.
// reset (rst_n, synchronous) empties the pool and fills the free stack, no sweep.
// a stalled result freezes the ring and the pipeline; no input is taken outside idle.
`default_nettype none
module particle_pool_update_core #(
  parameter int POOL_SIZE = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_operation,
  input  wire logic [31:0] in_time_ms,
  input  wire logic [31:0] in_color_rgba,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_y,
  input  wire logic signed [31:0] in_pos_z,
  input  wire logic signed [31:0] in_vel_x,
  input  wire logic signed [31:0] in_vel_y,
  input  wire logic signed [31:0] in_vel_z,
  input  wire logic [7:0]  in_point_size,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_accepted,
  output logic             out_has_particle,
  output logic [5:0]       out_slot,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic [31:0]      out_color,
  output logic [7:0]       out_size,
  output logic             out_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);
  import ppu_pkg::*;

  localparam int AW   = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int CNTW = $clog2(POOL_SIZE + 1);
  localparam int RING = POOL_SIZE + UPD_LAT;
  localparam int CW   = $clog2(RING);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SPAWN = 4'b0010,
    ST_TICK  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   cyc_r;
  logic [CNTW-1:0] count_r, count_nxt;
  logic [CNTW-1:0] wm_r;
  logic [15:0]     life_r;
  logic [31:0]     last_time_r;
  logic [31:0]     dt_r;
  particle_t       sp_r;
  result_t         out_r, out_d, pend_r;
  logic            out_valid_r, pend_v_r, out_load;

  logic            adv, in_acc, shift, spawn_ok;
  logic [CNTW-1:0] top;
  logic [5:0]      spawn_slot;
  logic [5:0]      ram_q;
  particle_t       ring_q [POOL_SIZE];
  particle_t       upd_q;
  logic [5:0]      upd_slot;
  push_t           push;
  particle_t       load_d;

  // handshakes, register writes only while idle with no item offered
  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign shift     = (state_r == ST_TICK) && adv;
  assign cfg_ready = (state_r == ST_IDLE) && !in_valid;

  // free stack top: entries below the low water mark still hold their reset order
  assign top        = count_r - CNTW'(1);
  assign spawn_slot = (top < wm_r) ? 6'(CNTW'(POOL_SIZE - 1) - top) : ram_q;
  assign spawn_ok   = (state_r == ST_SPAWN) && adv && (count_r != '0);

  ppu_ram #(.WIDTH(6), .DEPTH(POOL_SIZE)) u_stack (
    .clk   (clk),
    .we    (push.valid),
    .waddr (count_r[AW-1:0]),
    .wdata (push.slot),
    .raddr (top[AW-1:0]),
    .rdata (ram_q)
  );

  // new particle for the chosen cell
  always_comb begin
    load_d       = sp_r;
    load_d.alive = 1'b1;
    load_d.age   = '0;
  end

  // ring of slot cells closed through the update pipeline
  for (genvar j = 0; j < POOL_SIZE; j++) begin : g_ring
    if (j == POOL_SIZE - 1) begin : g_tail
      ppu_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift),
        .d_in     (upd_q),
        .load_en  (spawn_ok && (spawn_slot == 6'(j))),
        .load_d   (load_d),
        .q        (ring_q[j])
      );
    end else begin : g_body
      ppu_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift),
        .d_in     (ring_q[j+1]),
        .load_en  (spawn_ok && (spawn_slot == 6'(j))),
        .load_d   (load_d),
        .q        (ring_q[j])
      );
    end
  end

  ppu_update u_update (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (shift),
    .dt        (dt_r),
    .life_lim  (life_r),
    .d_in      (ring_q[0]),
    .slot_in   (6'(cyc_r)),
    .d_out     (upd_q),
    .slot_out  (upd_slot),
    .push      (push)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_operation == OP_TICK) ? ST_TICK : ST_SPAWN;
        end
      end
      ST_SPAWN: begin
        if (adv) state_nxt = ST_IDLE;
      end
      ST_TICK: begin
        if (shift && (cyc_r == CW'(RING - 1))) state_nxt = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (adv) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // result selection
  always_comb begin
    out_load = 1'b0;
    out_d    = '0;
    case (state_r)
      ST_SPAWN: begin
        out_load = 1'b1;
        out_d.last = 1'b1;
        if (count_r != '0) begin
          out_d.accepted     = 1'b1;
          out_d.has_particle = 1'b1;
          out_d.slot         = spawn_slot;
          out_d.x            = sp_r.x;
          out_d.y            = sp_r.y;
          out_d.z            = sp_r.z;
          out_d.color        = sp_r.color;
          out_d.size         = sp_r.size;
        end
      end
      ST_TICK: begin
        if (upd_q.alive && pend_v_r) begin
          out_load = 1'b1;
          out_d    = pend_r;
        end
      end
      ST_FLUSH: begin
        out_load = 1'b1;
        if (pend_v_r) begin
          out_d = pend_r;
        end else begin
          out_d.accepted = 1'b1;
        end
        out_d.last = 1'b1;
      end
      default: out_load = 1'b0;
    endcase
  end

  // free count
  always_comb begin
    count_nxt = count_r;
    if (push.valid) begin
      count_nxt = count_r + CNTW'(1);
    end else if (spawn_ok) begin
      count_nxt = top;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cyc_r       <= '0;
      count_r     <= CNTW'(POOL_SIZE);
      wm_r        <= CNTW'(POOL_SIZE);
      life_r      <= LIFE_RESET;
      last_time_r <= '0;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (spawn_ok && (top < wm_r)) begin
        wm_r <= top;
      end
      if (in_acc) begin
        cyc_r <= '0;
      end else if (shift) begin
        cyc_r <= cyc_r + CW'(1);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LIFETIME:   life_r      <= cfg_data[15:0];
          CFG_START_TIME: last_time_r <= cfg_data;
          default: ;
        endcase
      end
      if (in_acc && (in_operation == OP_TICK)) begin
        last_time_r <= in_time_ms;
      end
      if (adv) begin
        out_valid_r <= out_load;
      end
      if (shift && upd_q.alive) begin
        pend_v_r <= 1'b1;
      end else if ((state_r == ST_FLUSH) && adv) begin
        pend_v_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      dt_r       <= in_time_ms - last_time_r;
      sp_r.alive <= 1'b1;
      sp_r.age   <= '0;
      sp_r.x     <= in_pos_x;
      sp_r.y     <= in_pos_y;
      sp_r.z     <= in_pos_z;
      sp_r.vx    <= in_vel_x;
      sp_r.vy    <= in_vel_y;
      sp_r.vz    <= in_vel_z;
      sp_r.color <= in_color_rgba;
      sp_r.size  <= in_point_size;
    end
    if (adv && out_load) begin
      out_r <= out_d;
    end
    if (shift && upd_q.alive) begin
      pend_r.accepted     <= 1'b1;
      pend_r.has_particle <= 1'b1;
      pend_r.slot         <= upd_slot;
      pend_r.x            <= upd_q.x;
      pend_r.y            <= upd_q.y;
      pend_r.z            <= upd_q.z;
      pend_r.color        <= upd_q.color;
      pend_r.size         <= upd_q.size;
      pend_r.last         <= 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_accepted     = out_r.accepted;
  assign out_has_particle = out_r.has_particle;
  assign out_slot         = out_r.slot;
  assign out_x            = out_r.x;
  assign out_y            = out_r.y;
  assign out_z            = out_r.z;
  assign out_color        = out_r.color;
  assign out_size         = out_r.size;
  assign out_last         = out_r.last;

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNTW'(POOL_SIZE))
    else $error("free count above pool size");

  a_mark_below_count: assert property (@(posedge clk) disable iff (!rst_n)
    wm_r <= count_r)
    else $error("low water mark above free count");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pend_v_r)
    else $error("survivor left pending after a tick");

  a_push_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> (state_r == ST_TICK) && (count_r < CNTW'(POOL_SIZE)))
    else $error("slot freed outside a tick or into a full stack");

  a_tick_ends_flush: assert property (@(posedge clk) disable iff (!rst_n)
    shift && (cyc_r == CW'(RING - 1)) |=> (state_r == ST_FLUSH))
    else $error("tick did not close after a full rotation");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import ppu_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_operation = OP_SPAWN;
  logic [31:0] in_time_ms = '0;
  logic [31:0] in_color_rgba = '0;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic signed [31:0] in_vel_x = '0, in_vel_y = '0, in_vel_z = '0;
  logic [7:0] in_point_size = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_accepted, out_has_particle, out_last;
  logic [5:0] out_slot;
  logic signed [31:0] out_x, out_y, out_z;
  logic [31:0] out_color;
  logic [7:0] out_size;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = CFG_LIFETIME;
  logic [31:0] cfg_data = '0;

  particle_pool_update_core u_top (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow pool state
  logic        pool_alive [64];
  logic [31:0] pool_age [64];
  logic signed [31:0] pool_x [64], pool_y [64], pool_z [64];
  logic signed [31:0] pool_vx [64], pool_vy [64], pool_vz [64];
  logic [31:0] pool_color [64];
  logic [7:0]  pool_size [64];
  logic [5:0]  free_slots [64];
  int          free_cnt;
  logic [15:0] life_limit;
  logic [31:0] last_tick;

  result_t expected_results[$];
  int errors = 0;
  int idle_cycles = 0;
  bit in_gaps = 1'b1, out_gaps = 1'b1;
  int hold_off = 0;
  int hold_req = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic queue_result(input result_t r);
    expected_results.insert(expected_results.size(), r);
  endtask

  function automatic logic signed [31:0] moved(input logic signed [31:0] p,
                                              input logic signed [31:0] v,
                                              input logic [31:0] dt);
    logic signed [63:0] step;
    logic signed [63:0] s;
    step = (64'(signed'(v)) * signed'({32'd0, dt})) / 64'sd1000;
    s = 64'(signed'(p)) + step;
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s[31:0];
  endfunction

  function automatic result_t particle_result(input int i, input logic lst);
    result_t r;
    r.accepted = 1'b1; r.has_particle = 1'b1; r.slot = 6'(i);
    r.x = pool_x[i]; r.y = pool_y[i]; r.z = pool_z[i];
    r.color = pool_color[i]; r.size = pool_size[i]; r.last = lst;
    return r;
  endfunction

  function automatic result_t empty_result(input logic acc);
    result_t r;
    r = '0; r.accepted = acc; r.last = 1'b1;
    return r;
  endfunction

  task automatic pool_reset();
    for (int k = 0; k < 64; k++) begin
      pool_alive[k] = 1'b0;
      free_slots[k] = 6'(63 - k);
    end
    free_cnt = 64;
    life_limit = LIFE_RESET;
    last_tick = '0;
  endtask

  // work out the results of one item and update the shadow pool
  task automatic predict_item(input logic op, input logic [31:0] t, input logic [31:0] col,
                              input logic signed [31:0] px, py, pz, vx, vy, vz,
                              input logic [7:0] sz);
    int i;
    logic [31:0] dt;
    result_t held;
    bit have_held;
    if (op == OP_SPAWN) begin
      if (free_cnt == 0) begin
        queue_result(empty_result(1'b0));
      end else begin
        free_cnt--;
        i = int'(free_slots[free_cnt]);
        pool_alive[i] = 1'b1; pool_age[i] = '0; pool_color[i] = col;
        pool_x[i] = px; pool_y[i] = py; pool_z[i] = pz;
        pool_vx[i] = vx; pool_vy[i] = vy; pool_vz[i] = vz; pool_size[i] = sz;
        queue_result(particle_result(i, 1'b1));
      end
    end else begin
      dt = t - last_tick;
      have_held = 1'b0;
      held = '0;
      for (int k = 0; k < 64; k++) begin
        if (!pool_alive[k]) continue;
        if (pool_age[k] > {16'd0, life_limit}) begin
          pool_alive[k] = 1'b0;
          free_slots[free_cnt] = 6'(k);
          free_cnt++;
        end else begin
          pool_x[k] = moved(pool_x[k], pool_vx[k], dt);
          pool_y[k] = moved(pool_y[k], pool_vy[k], dt);
          pool_z[k] = moved(pool_z[k], pool_vz[k], dt);
          pool_age[k] = (pool_age[k] > 32'hFFFF_FFFF - dt) ? 32'hFFFF_FFFF : pool_age[k] + dt;
          if (have_held) queue_result(held);
          held = particle_result(k, 1'b0);
          have_held = 1'b1;
        end
      end
      last_tick = t;
      if (!have_held) begin
        queue_result(empty_result(1'b1));
      end else begin
        held.last = 1'b1;
        queue_result(held);
      end
    end
  endtask

  // send one item, predicting at acceptance; valid stays up until the next gap
  task automatic send_item(input logic op, input logic [31:0] t, input logic [31:0] col,
                           input logic signed [31:0] px, py, pz, vx, vy, vz,
                           input logic [7:0] sz);
    int gap;
    if (in_gaps && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1; in_operation <= op; in_time_ms <= t; in_color_rgba <= col;
    in_pos_x <= px; in_pos_y <= py; in_pos_z <= pz;
    in_vel_x <= vx; in_vel_y <= vy; in_vel_z <= vz; in_point_size <= sz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(op, t, col, px, py, pz, vx, vy, vz, sz);
  endtask

  task automatic spawn_random();
    send_item(OP_SPAWN, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, 8'($urandom));
  endtask

  // modest velocities and positions so particles survive a while
  task automatic spawn_tame();
    send_item(OP_SPAWN, $urandom, $urandom,
              $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000,
              $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000,
              $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000,
              $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000,
              $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000,
              $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000, 8'($urandom));
  endtask

  task automatic tick_at(input logic [31:0] t);
    send_item(OP_TICK, t, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, 8'($urandom));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (UPD_LAT + 8) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_LIFETIME) life_limit = val[15:0];
    else last_tick = val;
    @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report("unexpected result", {63'd0, out_last}, 64'd0);
      end else begin
        want = expected_results.pop_front();
        if (out_accepted !== want.accepted) report("accepted", out_accepted, want.accepted);
        if (out_has_particle !== want.has_particle)
          report("has_particle", out_has_particle, want.has_particle);
        if (out_slot !== want.slot) report("slot", out_slot, want.slot);
        if (out_x !== want.x) report("x", out_x, want.x);
        if (out_y !== want.y) report("y", out_y, want.y);
        if (out_z !== want.z) report("z", out_z, want.z);
        if (out_color !== want.color) report("colour", out_color, want.color);
        if (out_size !== want.size) report("size", out_size, want.size);
        if (out_last !== want.last) report("last", out_last, want.last);
      end
    end
  end

  // receiver stall: random bursts or a long hold-off on request
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_off <= hold_req - 1;
      hold_req = 0;
      out_stall <= 1'b1;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else if (out_gaps && $urandom_range(0, 7) == 0) begin
      hold_off <= $urandom_range(0, 12);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic test_directed();
    // extremes of every field, time wrapping backwards, saturating motion
    send_item(OP_SPAWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 0,
              32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 8'hFF);
    send_item(OP_SPAWN, 0, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
              32'sh8000_0000, 32'sh7FFF_FFFF, 0, 8'h00);
    send_item(OP_SPAWN, 0, 32'h1234_5678, 32'sh0001_0000, -32'sh0001_0000, 0,
              32'sh0000_03E7, -32'sh0000_03E7, 32'sh0000_0001, 8'h08);
    tick_at(32'd1);
    tick_at(32'd1001);
    tick_at(32'd0);                 // time goes backwards: huge dt
    tick_at(32'd4000);              // ages saturated, all die
    tick_at(32'd4001);              // no survivors
    tick_at(32'hFFFF_FFFF);
  endtask

  task automatic test_pool_full();
    for (int k = 0; k < 66; k++) spawn_tame();
    tick_at(last_tick + 10);
  endtask

  task automatic test_config();
    wait_drained();
    write_reg(CFG_LIFETIME, 32'd0);
    write_reg(CFG_START_TIME, 32'hFFFF_FFF0);
    tick_at(32'hFFFF_FFF5);         // aged particles die at a zero life span
    tick_at(32'h0000_0004);         // time wraps, nothing left
    spawn_tame();
    tick_at(32'd10);
    wait_drained();
    write_reg(CFG_LIFETIME, 32'd65535);
    write_reg(CFG_START_TIME, 32'd0);
  endtask

  task automatic test_hold_off();
    wait_drained();
    hold_req = 400;
    for (int k = 0; k < 6; k++) spawn_tame();
    tick_at(last_tick + 5);
    tick_at(last_tick + 5);
    spawn_tame();
    // sender waits for every result
    wait_drained();
  endtask

  task automatic test_random(input int count);
    logic [31:0] t;
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(0, 9))
        0: spawn_random();
        1, 2: begin
          t = ($urandom_range(0, 7) == 0) ? $urandom : last_tick + $urandom_range(0, 2000);
          tick_at(t);
        end
        default: spawn_tame();
      endcase
      if (k == count - 40) begin
        in_gaps = 1'b0;
        out_gaps = 1'b0;
      end
    end
  endtask

  initial begin
    pool_reset();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_pool_full();
    test_config();
    test_hold_off();
    wait_drained();
    write_reg(CFG_LIFETIME, 32'd3000);
    test_random(130);
    wait_drained();
    write_reg(CFG_LIFETIME, 32'd500);
    write_reg(CFG_START_TIME, $urandom);
    test_random(100);
    wait_drained();
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule
